[rtl/pdx_pkg.sv]
package pdx_pkg;

  localparam int MaxPayload = 8;
  localparam int IdxW       = $clog2(MaxPayload);
  localparam int LenW       = 4;
  localparam int ByteW      = 8;
  localparam int OutDataW   = 80;

  localparam logic [ByteW-1:0] START_BYTE = 8'h02;
  localparam logic [ByteW-1:0] END_BYTE   = 8'h03;

  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_TAKE    = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_CMD  = 3'd1,
    PH_LEN  = 3'd2,
    PH_PAY  = 3'd3,
    PH_CHK  = 3'd4,
    PH_END  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [MaxPayload-1:0][ByteW-1:0] payload;
    logic [LenW-1:0]                  payload_len;
    logic [ByteW-1:0]                 command;
  } pdx_result_t;

endpackage

[rtl/pdx_parser.sv]
module pdx_parser
  import pdx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  input  logic        req_op,
  input  logic [7:0]  req_byte,
  output logic        res_valid,
  output pdx_result_t res
);

  phase_t                 phase_r, phase_nxt;
  logic [ByteW-1:0]       cmd_r, cmd_nxt;
  logic [LenW-1:0]        len_r, len_nxt;
  logic [LenW-1:0]        idx_r, idx_nxt;
  logic [ByteW-1:0]       chk_r, chk_nxt;
  logic                   full_r, full_nxt;
  logic [ByteW-1:0]       store_r [MaxPayload];
  logic                   store_we;
  logic [LenW:0]          idx_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cmd_r   <= '0;
      len_r   <= '0;
      idx_r   <= '0;
      chk_r   <= '0;
      full_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      chk_r   <= chk_nxt;
      full_r  <= full_nxt;
    end
  end

  // payload store, undefined until written
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[idx_r[IdxW-1:0]] <= req_byte;
    end
  end

  assign idx_inc = {1'b0, idx_r} + {{LenW{1'b0}}, 1'b1};

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    chk_nxt   = chk_r;
    full_nxt  = full_r;
    store_we  = 1'b0;
    res_valid = 1'b0;
    if (req_valid) begin
      if (req_op == OP_TAKE) begin
        full_nxt = 1'b0;
      end else begin
        case (phase_r)
          PH_CMD: begin
            cmd_nxt   = req_byte;
            chk_nxt   = req_byte;
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            len_nxt = req_byte[LenW-1:0];
            chk_nxt = chk_r ^ req_byte;
            idx_nxt = '0;
            if (req_byte > ByteW'(MaxPayload)) begin
              phase_nxt = PH_HUNT;
            end else if (req_byte != '0) begin
              phase_nxt = PH_PAY;
            end else begin
              phase_nxt = PH_CHK;
            end
          end
          PH_PAY: begin
            store_we = 1'b1;
            chk_nxt  = chk_r ^ req_byte;
            idx_nxt  = idx_inc[LenW-1:0];
            if (idx_inc >= {1'b0, len_r}) begin
              phase_nxt = PH_CHK;
            end
          end
          PH_CHK: begin
            phase_nxt = (req_byte == chk_r) ? PH_END : PH_HUNT;
          end
          PH_END: begin
            phase_nxt = PH_HUNT;
            if (req_byte == END_BYTE && !full_r) begin
              full_nxt  = 1'b1;
              res_valid = 1'b1;
            end
          end
          default: begin
            if (req_byte == START_BYTE) begin
              phase_nxt = PH_CMD;
              chk_nxt   = '0;
            end else begin
              phase_nxt = PH_HUNT;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    res.command     = cmd_r;
    res.payload_len = len_r;
    for (int k = 0; k < MaxPayload; k++) begin
      res.payload[k] = ({1'b0, len_r} > (LenW+1)'(k)) ? store_r[k] : '0;
    end
  end

endmodule

[rtl/pdx_skid.sv]
module pdx_skid
  import pdx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  pdx_result_t push_data,
  output logic        space,
  output logic        pop_valid,
  input  logic        pop_ready,
  output pdx_result_t pop_data
);

  logic        main_valid_r, skid_valid_r;
  pdx_result_t main_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop_ready || !main_valid_r) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready || !main_valid_r) begin
      main_r <= skid_valid_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

  assign space     = !skid_valid_r;
  assign pop_valid = main_valid_r;
  assign pop_data  = main_r;

endmodule

[rtl/packet_deframer_xor_check.sv]
// stx/etx packet deframer with xor check and a one-packet mailbox
// in_ channel: one request per received link byte (in_tuser = 0, byte in
//   in_tdata) or a mailbox release from the consumer (in_tuser = 1)
// out_ channel: one request per good frame, carrying command, length and
//   eight payload bytes (bytes beyond the length read zero)
// a good frame is delivered only while the mailbox is free, otherwise it
//   is dropped; a release request frees the mailbox again
// output: the result of the end byte is registered on out_ when that byte is
//   accepted, or held in the skid entry while out_ is stalled
// throughput: one request per cycle while in_tready is high, set by the frame
//   state machine
// reset (rst_n low, synchronous): hunts for a start byte, mailbox free,
//   output empty
// receiver stall: a two-entry output register absorbs one pending result;
//   in_tready drops only while both entries are occupied
module packet_deframer_xor_check
  import pdx_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // rx_byte
  input  logic                in_tuser,   // op
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata   // command, payload_len, byte0..byte7, zero fill
);

  logic        accept;
  logic        res_valid;
  logic        space;
  pdx_result_t res;
  pdx_result_t pop_data;

  assign in_tready = space;
  assign accept    = in_tvalid && space;

  pdx_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (accept),
    .req_op    (in_tuser),
    .req_byte  (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  pdx_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (pop_data)
  );

  assign out_tdata = {{(OutDataW - $bits(pdx_result_t)){1'b0}}, pop_data};

endmodule
